### rtl/core/asmtok_pkg.sv
// shared types and constants of the assembler character tokenizer
package asmtok_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_KEYWORD = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_STOPPED = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_STRING  = 3'd1,
    KIND_KEYWORD = 3'd2,
    KIND_COLON   = 3'd3,
    KIND_COMMA   = 3'd4,
    KIND_END     = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // result queue: two slots must be free before an item is decoded
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] content;
    logic       has;
    logic       done;
    logic       last;
  } res_t;

  typedef struct packed {
    mode_e      mode;
    logic       dec;
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } step_t;

endpackage

### rtl/core/asmtok_if.sv
// valid/ready channels for source bytes and token results
interface asmtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface asmtok_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] content_byte;
  logic       has_content;
  logic       token_done;
  logic       run_last;

  modport source (output valid, output token_kind, output content_byte, output has_content,
                  output token_done, output run_last, input ready);
  modport sink (input valid, input token_kind, input content_byte, input has_content,
                input token_done, input run_last, output ready);
endinterface

### rtl/core/asmtok_step.sv
// per-byte lexer decode: next mode and up to two results
module asmtok_step (
  input  asmtok_pkg::mode_e mode_i,
  input  logic              dec_i,
  input  logic [7:0]        byte_i,
  output asmtok_pkg::step_t step_o
);
  import asmtok_pkg::*;

  logic  is_digit;
  logic  is_alpha;
  logic  st_n;
  res_t  st_res;
  mode_e st_mode;
  logic  st_dec;
  res_t  marker;
  res_t  content_res;

  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_alpha = ((byte_i >= 8'h61) && (byte_i <= 8'h7A)) ||
                    ((byte_i >= 8'h41) && (byte_i <= 8'h5A));

  // handling of the byte as the first character of a token
  always_comb begin
    st_n    = 1'b0;
    st_res  = '{kind: KIND_ERROR, content: 8'h00, has: 1'b0, done: 1'b1, last: 1'b1};
    st_mode = MODE_IDLE;
    st_dec  = dec_i;
    if (is_digit) begin
      st_n    = 1'b1;
      st_mode = MODE_NUMBER;
      st_dec  = 1'b0;
      st_res  = '{kind: KIND_NUMBER, content: byte_i, has: 1'b1, done: 1'b0, last: 1'b1};
    end else if (is_alpha) begin
      st_n    = 1'b1;
      st_mode = MODE_KEYWORD;
      st_res  = '{kind: KIND_KEYWORD, content: byte_i, has: 1'b1, done: 1'b0, last: 1'b1};
    end else if (byte_i == CH_QUOTE) begin
      st_mode = MODE_STRING;
    end else if (byte_i == CH_SPACE || byte_i == CH_TAB || byte_i == CH_LF) begin
      st_mode = MODE_IDLE;
    end else if (byte_i == CH_SEMI) begin
      st_mode = MODE_COMMENT;
    end else if (byte_i == CH_COMMA) begin
      st_n   = 1'b1;
      st_res = '{kind: KIND_COMMA, content: byte_i, has: 1'b1, done: 1'b1, last: 1'b1};
    end else if (byte_i == CH_COLON) begin
      st_n   = 1'b1;
      st_res = '{kind: KIND_COLON, content: byte_i, has: 1'b1, done: 1'b1, last: 1'b1};
    end else begin
      st_n        = 1'b1;
      st_mode     = MODE_STOPPED;
      st_res.kind = (byte_i == CH_NUL) ? KIND_END : KIND_ERROR;
    end
  end

  always_comb begin
    marker      = '{kind: KIND_NUMBER, content: 8'h00, has: 1'b0, done: 1'b1, last: ~st_n};
    content_res = '{kind: KIND_NUMBER, content: byte_i, has: 1'b1, done: 1'b0, last: 1'b1};
    step_o      = '{mode: mode_i, dec: dec_i, count: 2'd0, res0: st_res, res1: st_res};
    unique case (mode_i)
      MODE_IDLE: begin
        step_o.mode  = st_mode;
        step_o.dec   = st_dec;
        step_o.count = {1'b0, st_n};
      end
      MODE_NUMBER: begin
        if (is_digit || (byte_i == CH_DOT && !dec_i)) begin
          step_o.count = 2'd1;
          step_o.res0  = content_res;
          if (byte_i == CH_DOT) begin
            step_o.dec = 1'b1;
          end
        end else begin
          step_o.mode  = st_mode;
          step_o.dec   = st_dec;
          step_o.count = st_n ? 2'd2 : 2'd1;
          step_o.res0  = marker;
        end
      end
      MODE_KEYWORD: begin
        if (is_alpha || is_digit || byte_i == CH_UNDER || byte_i == CH_DOT) begin
          step_o.count     = 2'd1;
          step_o.res0      = content_res;
          step_o.res0.kind = KIND_KEYWORD;
        end else begin
          step_o.mode      = st_mode;
          step_o.dec       = st_dec;
          step_o.count     = st_n ? 2'd2 : 2'd1;
          step_o.res0      = marker;
          step_o.res0.kind = KIND_KEYWORD;
        end
      end
      MODE_STRING: begin
        step_o.count = 2'd1;
        if (byte_i == CH_QUOTE) begin
          step_o.mode = MODE_IDLE;
          step_o.res0 = '{kind: KIND_STRING, content: 8'h00, has: 1'b0, done: 1'b1, last: 1'b1};
        end else if (byte_i == CH_NUL) begin
          step_o.mode = MODE_STOPPED;
          step_o.res0 = '{kind: KIND_ERROR, content: 8'h00, has: 1'b0, done: 1'b1, last: 1'b1};
        end else begin
          step_o.res0      = content_res;
          step_o.res0.kind = KIND_STRING;
        end
      end
      MODE_COMMENT: begin
        if (byte_i == CH_LF) begin
          step_o.mode = MODE_IDLE;
        end else if (byte_i == CH_NUL) begin
          // zero byte closes the comment and is then an end of input
          step_o.mode  = st_mode;
          step_o.count = 2'd1;
        end
      end
      default: begin
        step_o.mode = MODE_STOPPED;
      end
    endcase
  end

endmodule

### rtl/core/assembler_char_tokenizer_core.sv
// top level: input byte register, lexer decode and result queue
// an accepted byte is held in the input byte register, then decoded into the result queue
// throughput: one source byte per cycle unless the queue stalls the input; a byte that
//   ends a number or keyword and starts another token gives two results, taken one per cycle
// the result queue holds four items; input stalls when fewer than two slots are free
// reset: asynchronous, clears mode, queue pointers and valid flags; queue data is not reset
module assembler_char_tokenizer_core (
  input logic         clk_i,
  input logic         rst_ni,
  asmtok_in_if.sink   in_i,
  asmtok_out_if.source out_o
);
  import asmtok_pkg::*;

  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  mode_e            mode_q, mode_d;
  logic             dec_q, dec_d;
  step_t            step;
  res_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push_ok;
  logic             consume;
  logic             pop;
  logic [CNT_W-1:0] push_n;
  res_t             head;

  asmtok_step u_step (
    .mode_i (mode_q),
    .dec_i  (dec_q),
    .byte_i (in_byte_q),
    .step_o (step)
  );

  assign push_ok    = (count_q <= CNT_W'(FIFO_DEPTH - 2));
  assign consume    = in_vld_q && push_ok;
  assign in_i.ready = !in_vld_q || push_ok;
  assign pop        = out_o.valid && out_o.ready;
  assign push_n     = consume ? CNT_W'(step.count) : '0;

  always_comb begin
    mode_d   = consume ? step.mode : mode_q;
    dec_d    = consume ? step.dec : dec_q;
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + push_n - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_IDLE;
      dec_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      mode_q   <= mode_d;
      dec_q    <= dec_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.source_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && step.count != 2'd0) begin
      fifo_q[wr_ptr_q] <= step.res0;
    end
    if (consume && step.count == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= step.res1;
    end
  end

  assign head               = fifo_q[rd_ptr_q];
  assign out_o.valid        = (count_q != '0);
  assign out_o.token_kind   = head.kind;
  assign out_o.content_byte = head.content;
  assign out_o.has_content  = head.has;
  assign out_o.token_done   = head.done;
  assign out_o.run_last     = head.last;

endmodule

### rtl/core/asmtok_checker.sv
// port-level checks for the tokenizer and their binding to the top level
module asmtok_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_kind_i,
  input logic [7:0] out_content_i,
  input logic       out_last_i
);
  import asmtok_pkg::*;

  logic stopped_q;

  // once end or error has gone out the block has nothing more to say
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
    end else if (out_valid_i && out_ready_i &&
                 (out_kind_i == KIND_END || out_kind_i == KIND_ERROR)) begin
      stopped_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
    $stable(out_content_i) && $stable(out_last_i))
    else $error("result dropped or changed while stalled");

  a_stop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_END || out_kind_i == KIND_ERROR) |-> out_last_i)
    else $error("end or error is not the last result of its byte");

  a_silent_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !out_valid_i)
    else $error("result after end or error");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  a_in_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> out_valid_i || in_ready_i)
    else $error("input stall without result backlog");

endmodule

bind assembler_char_tokenizer_core asmtok_checker u_asmtok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_kind_i    (out_o.token_kind),
  .out_content_i (out_o.content_byte),
  .out_last_i    (out_o.run_last)
);

### sim/assembler_char_tokenizer_core_tb.sv
// testbench for the assembler character tokenizer core: directed table, random text, predictor
`timescale 1ns / 100ps

module assembler_char_tokenizer_core_tb;
  import asmtok_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 950;
  localparam int DRAIN_CYCLES = 8;
  localparam res_t NO_TOK     = '0;

  // one source byte, optionally with its results written out by hand
  typedef struct packed {
    logic [7:0] src;
    logic       typed;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } row_t;

  logic clk_i;
  logic rst_ni;

  asmtok_in_if  byte_ch ();
  asmtok_out_if token_ch ();

  assembler_char_tokenizer_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (token_ch)
  );

  mode_e lex_state   = MODE_IDLE;
  logic  point_seen  = 1'b0;
  res_t  pending_tokens[$];
  row_t  sent_rows[$];
  int    tx_idle_pct  = 22;
  int    rx_idle_pct  = 50;
  int    quiet_cycles = 0;
  int    mismatches   = 0;
  int    bytes_sent   = 0;
  int    tokens_seen  = 0;
  bit    after_number = 1'b0;
  string stop_case    = "none";

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic res_t tok(kind_e k, logic [7:0] b, logic h, logic d, logic l);
    res_t r;
    r.kind    = k;
    r.content = b;
    r.has     = h;
    r.done    = d;
    r.last    = l;
    return r;
  endfunction

  function automatic row_t typed_row(logic [7:0] src, logic [1:0] n, res_t r0, res_t r1);
    row_t r;
    r.src   = src;
    r.typed = 1'b1;
    r.n     = n;
    r.r0    = r0;
    r.r1    = r1;
    return r;
  endfunction

  function automatic row_t pred_row(logic [7:0] src);
    row_t r;
    r     = '0;
    r.src = src;
    return r;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // byte seen with no token open
  function automatic int start_token(logic [7:0] c, output res_t r);
    int n;
    n = 0;
    r = NO_TOK;
    if (is_digit(c)) begin
      lex_state  = MODE_NUMBER;
      point_seen = 1'b0;
      r = tok(KIND_NUMBER, c, 1'b1, 1'b0, 1'b1);
      n = 1;
    end else if (is_alpha(c)) begin
      lex_state = MODE_KEYWORD;
      r = tok(KIND_KEYWORD, c, 1'b1, 1'b0, 1'b1);
      n = 1;
    end else if (c == CH_QUOTE) begin
      lex_state = MODE_STRING;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
      lex_state = MODE_IDLE;
    end else if (c == CH_SEMI) begin
      lex_state = MODE_COMMENT;
    end else if (c == CH_COMMA) begin
      lex_state = MODE_IDLE;
      r = tok(KIND_COMMA, c, 1'b1, 1'b1, 1'b1);
      n = 1;
    end else if (c == CH_COLON) begin
      lex_state = MODE_IDLE;
      r = tok(KIND_COLON, c, 1'b1, 1'b1, 1'b1);
      n = 1;
    end else begin
      lex_state = MODE_STOPPED;
      if (c == CH_NUL) r = tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
      else r = tok(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1);
      n = 1;
    end
    return n;
  endfunction

  // end marker of the open number or keyword, then the byte starts afresh
  function automatic int close_then_start(kind_e k, logic [7:0] c, output res_t r0,
                                          output res_t r1);
    int n;
    r0 = tok(k, 8'h00, 1'b0, 1'b1, 1'b1);
    lex_state = MODE_IDLE;
    n = start_token(c, r1);
    if (n > 0) r0.last = 1'b0;
    return 1 + n;
  endfunction

  function automatic int lex_byte(logic [7:0] c, output res_t r0, output res_t r1);
    int n;
    n  = 0;
    r0 = NO_TOK;
    r1 = NO_TOK;
    case (lex_state)
      MODE_IDLE: begin
        n = start_token(c, r0);
      end
      MODE_NUMBER: begin
        if (is_digit(c) || (c == CH_DOT && !point_seen)) begin
          if (c == CH_DOT) point_seen = 1'b1;
          r0 = tok(KIND_NUMBER, c, 1'b1, 1'b0, 1'b1);
          n = 1;
        end else begin
          n = close_then_start(KIND_NUMBER, c, r0, r1);
        end
      end
      MODE_KEYWORD: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT) begin
          r0 = tok(KIND_KEYWORD, c, 1'b1, 1'b0, 1'b1);
          n = 1;
        end else begin
          n = close_then_start(KIND_KEYWORD, c, r0, r1);
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          lex_state = MODE_IDLE;
          r0 = tok(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
        end else if (c == CH_NUL) begin
          lex_state = MODE_STOPPED;
          r0 = tok(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
          r0 = tok(KIND_STRING, c, 1'b1, 1'b0, 1'b1);
        end
        n = 1;
      end
      MODE_COMMENT: begin
        if (c == CH_LF) lex_state = MODE_IDLE;
        else if (c == CH_NUL) n = start_token(c, r0);
      end
      default: begin
        lex_state = MODE_STOPPED;
      end
    endcase
    return n;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    token_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    res_t p0;
    res_t p1;
    row_t row;
    int   n;
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (token_ch.valid && token_ch.ready) begin
        tokens_seen++;
        got = tok(kind_e'(token_ch.token_kind), token_ch.content_byte, token_ch.has_content,
                  token_ch.token_done, token_ch.run_last);
        if (pending_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected token result, expected none, actual kind %0d content %0h",
                   $time, got.kind, got.content);
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", 8'(want.kind), 8'(got.kind));
          check_field("content_byte", want.content, got.content);
          check_field("has_content", 8'(want.has), 8'(got.has));
          check_field("token_done", 8'(want.done), 8'(got.done));
          check_field("run_last", 8'(want.last), 8'(got.last));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        row = sent_rows.pop_front();
        n = lex_byte(byte_ch.source_byte, p0, p1);
        if (row.typed) begin
          n  = int'(row.n);
          p0 = row.r0;
          p1 = row.r1;
        end
        if (n > 0) pending_tokens.push_back(p0);
        if (n > 1) pending_tokens.push_back(p1);
      end
    end
  end

  // valid stays high across back-to-back items
  task automatic feed(row_t row);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sent_rows.push_back(row);
    byte_ch.valid       <= 1'b1;
    byte_ch.source_byte <= row.src;
    bytes_sent++;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0:       b = CH_SPACE;
      1:       b = CH_TAB;
      default: b = CH_LF;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rand_word_char();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0:       b = rand_letter();
      1:       b = rand_digit();
      2:       b = CH_UNDER;
      default: b = CH_DOT;
    endcase
    return b;
  endfunction

  // one well-formed token, comment or run of blanks with random content, sometimes butted against the next
  task automatic emit_token();
    int         pick;
    bit         dot;
    logic [7:0] b;
    pick = $urandom_range(0, 9);
    // two numbers run together could meet a second point, which would stop the block
    if (after_number && pick <= 1) feed(pred_row(CH_SPACE));
    after_number = 1'b0;
    case (pick)
      0, 1: begin
        dot = 1'b0;
        feed(pred_row(rand_digit()));
        repeat ($urandom_range(0, 5)) begin
          if (!dot && $urandom_range(0, 3) == 0) begin
            dot = 1'b1;
            feed(pred_row(CH_DOT));
          end else begin
            feed(pred_row(rand_digit()));
          end
        end
        after_number = 1'b1;
      end
      2, 3: begin
        feed(pred_row(rand_letter()));
        repeat ($urandom_range(0, 6)) feed(pred_row(rand_word_char()));
      end
      4: begin
        feed(pred_row(CH_QUOTE));
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_QUOTE) b = 8'h23;
          feed(pred_row(b));
        end
        feed(pred_row(CH_QUOTE));
      end
      5: begin
        feed(pred_row(CH_SEMI));
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_LF) b = 8'h0B;
          feed(pred_row(b));
        end
        feed(pred_row(CH_LF));
      end
      6:       feed(pred_row(CH_COMMA));
      7:       feed(pred_row(CH_COLON));
      default: repeat ($urandom_range(1, 3)) feed(pred_row(rand_blank()));
    endcase
    if ($urandom_range(0, 9) < 6) begin
      feed(pred_row(rand_blank()));
      after_number = 1'b0;
    end
  endtask

  initial begin : stimulus
    row_t directed[$];
    int   target;
    byte_ch.valid       <= 1'b0;
    byte_ch.source_byte <= 8'h00;
    rst_ni              <= 1'b0;

    directed = '{
      typed_row(CH_COLON, 2'd1, tok(KIND_COLON, CH_COLON, 1'b1, 1'b1, 1'b1), NO_TOK),
      typed_row(CH_COMMA, 2'd1, tok(KIND_COMMA, CH_COMMA, 1'b1, 1'b1, 1'b1), NO_TOK),
      typed_row(CH_SPACE, 2'd0, NO_TOK, NO_TOK),
      typed_row("0", 2'd1, tok(KIND_NUMBER, "0", 1'b1, 1'b0, 1'b1), NO_TOK),
      pred_row(CH_DOT),
      pred_row("9"),
      pred_row(CH_SPACE),
      typed_row("A", 2'd1, tok(KIND_KEYWORD, "A", 1'b1, 1'b0, 1'b1), NO_TOK),
      pred_row(CH_UNDER),
      pred_row(CH_DOT),
      pred_row("7"),
      pred_row("z"),
      pred_row(CH_COMMA),
      pred_row("1"),
      pred_row("a"),
      pred_row(CH_QUOTE),
      typed_row(8'hFF, 2'd1, tok(KIND_STRING, 8'hFF, 1'b1, 1'b0, 1'b1), NO_TOK),
      typed_row(8'h01, 2'd1, tok(KIND_STRING, 8'h01, 1'b1, 1'b0, 1'b1), NO_TOK),
      pred_row(CH_SEMI),
      pred_row(CH_QUOTE),
      pred_row(CH_QUOTE),
      pred_row(CH_QUOTE),
      pred_row(CH_TAB),
      pred_row(CH_SEMI),
      typed_row(8'h80, 2'd0, NO_TOK, NO_TOK),
      pred_row(CH_LF),
      pred_row("Z"),
      pred_row(CH_COLON)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) feed(directed[i]);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 50 : 0;
      rx_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 22 : 0;
      target = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < target) emit_token();
    end

    // close any open token, then stop the stream in one of its ways
    feed(pred_row(CH_SPACE));
    case ($urandom_range(0, 5))
      0: begin
        stop_case = "a zero byte between tokens";
        feed(typed_row(CH_NUL, 2'd1, tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1), NO_TOK));
      end
      1: begin
        stop_case = "a zero byte inside a string";
        feed(pred_row(CH_QUOTE));
        feed(pred_row("x"));
        feed(typed_row(CH_NUL, 2'd1, tok(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1), NO_TOK));
      end
      2: begin
        stop_case = "a zero byte inside a comment";
        feed(pred_row(CH_SEMI));
        feed(pred_row("q"));
        feed(typed_row(CH_NUL, 2'd1, tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1), NO_TOK));
      end
      3: begin
        stop_case = "a second decimal point";
        feed(pred_row("4"));
        feed(pred_row(CH_DOT));
        feed(pred_row("2"));
        feed(typed_row(CH_DOT, 2'd2, tok(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 1'b0),
                       tok(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1)));
      end
      4: begin
        stop_case = "a zero byte ending a keyword";
        feed(pred_row("k"));
        feed(typed_row(CH_NUL, 2'd2, tok(KIND_KEYWORD, 8'h00, 1'b0, 1'b1, 1'b0),
                       tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1)));
      end
      default: begin
        stop_case = "a stray byte between tokens";
        feed(typed_row(8'($urandom_range(128, 255)), 2'd1,
                       tok(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1), NO_TOK));
      end
    endcase
    // stopped: further bytes are taken and give nothing
    repeat (6) feed(pred_row(8'($urandom_range(0, 255))));
    byte_ch.valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d source bytes and %0d token results under three idling patterns",
             bytes_sent, tokens_seen);
    $display("stream stopped by %s, %0d mismatches", stop_case, mismatches);
    if (mismatches == 0) begin
      $display("assembler_char_tokenizer_core_tb OK");
    end else begin
      $display("assembler_char_tokenizer_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("assembler_char_tokenizer_core_tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
rtl/core/asmtok_pkg.sv
rtl/core/asmtok_if.sv
rtl/core/asmtok_step.sv
rtl/core/assembler_char_tokenizer_core.sv
rtl/core/asmtok_checker.sv
sim/assembler_char_tokenizer_core_tb.sv
